// ===== src/bli_pkg.sv =====
// Shared types and constants for the battery level indicator.
// Level codes, charger and status codes, threshold set and reset values.
// No dependencies.
package bli_pkg;

  localparam int unsigned VoltW = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CUTOFF_LEVEL_DEFAULT = 1318;

  typedef logic [VoltW-1:0] volt_t;

  typedef enum logic [2:0] {
    LV_IDLE    = 3'd0,
    LV_EXTREME = 3'd1,
    LV_ONE     = 3'd2,
    LV_TWO     = 3'd3,
    LV_THREE   = 3'd4,
    LV_FOUR    = 3'd5,
    LV_FULL    = 3'd6
  } level_t;

  localparam logic [1:0] CS_OFF      = 2'd0;
  localparam logic [1:0] CS_STANDBY  = 2'd1;
  localparam logic [1:0] CS_CHARGING = 2'd2;
  localparam logic [1:0] CS_COMPLETE = 2'd3;

  localparam logic [1:0] ST_NORMAL   = 2'd0;
  localparam logic [1:0] ST_CHARGING = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_CHG_EXTREME = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CHG_MID     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CHG_HIGH    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CHG_FULL    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DIS_EXTREME = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DIS_LOW     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DIS_MID     = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_DIS_HIGH    = 3'd7;

  localparam volt_t RST_CHG_EXTREME = 12'd1364;
  localparam volt_t RST_CHG_MID     = 12'd1636;
  localparam volt_t RST_CHG_HIGH    = 12'd1773;
  localparam volt_t RST_CHG_FULL    = 12'd1864;
  localparam volt_t RST_DIS_EXTREME = 12'd1409;
  localparam volt_t RST_DIS_LOW     = 12'd1545;
  localparam volt_t RST_DIS_MID     = 12'd1636;
  localparam volt_t RST_DIS_HIGH    = 12'd1727;

  typedef struct packed {
    volt_t chg_extreme;
    volt_t chg_mid;
    volt_t chg_high;
    volt_t chg_full;
    volt_t dis_extreme;
    volt_t dis_low;
    volt_t dis_mid;
    volt_t dis_high;
  } thresh_t;

  typedef struct packed {
    level_t     level;
    logic       led;
    logic       poff;
    logic       chg;
    logic [1:0] status;
  } result_t;

endpackage

// ===== src/bli_cfg.sv =====
// Threshold register file for the battery level indicator.
// Depends on bli_pkg for the register indexes and reset values.
module bli_cfg
  import bli_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  volt_t              cfg_data,
  output thresh_t            thr
);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.chg_extreme <= RST_CHG_EXTREME;
      thr.chg_mid     <= RST_CHG_MID;
      thr.chg_high    <= RST_CHG_HIGH;
      thr.chg_full    <= RST_CHG_FULL;
      thr.dis_extreme <= RST_DIS_EXTREME;
      thr.dis_low     <= RST_DIS_LOW;
      thr.dis_mid     <= RST_DIS_MID;
      thr.dis_high    <= RST_DIS_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHG_EXTREME: thr.chg_extreme <= cfg_data;
        REG_CHG_MID:     thr.chg_mid     <= cfg_data;
        REG_CHG_HIGH:    thr.chg_high    <= cfg_data;
        REG_CHG_FULL:    thr.chg_full    <= cfg_data;
        REG_DIS_EXTREME: thr.dis_extreme <= cfg_data;
        REG_DIS_LOW:     thr.dis_low     <= cfg_data;
        REG_DIS_MID:     thr.dis_mid     <= cfg_data;
        REG_DIS_HIGH:    thr.dis_high    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/bli_update.sv =====
// Next-level, LED, shutdown and status logic for one tick of the battery level indicator.
// Purely combinational; depends on bli_pkg for level codes and types.
module bli_update
  import bli_pkg::*;
#(
  parameter int unsigned CUTOFF_LEVEL = CUTOFF_LEVEL_DEFAULT
) (
  input  level_t     level,
  input  logic       led,
  input  logic       ext_supply,
  input  logic [1:0] charger_state,
  input  volt_t      battery_voltage,
  input  thresh_t    thr,
  output result_t    res
);

  localparam volt_t Cutoff = volt_t'(CUTOFF_LEVEL);

  logic   chg;
  level_t lv_next;
  logic   led_next;
  logic   poff;

  assign chg = (charger_state == CS_CHARGING);

  always_comb begin
    lv_next  = level;
    led_next = led;
    poff     = 1'b0;
    if (ext_supply && chg) begin
      case (level)
        LV_IDLE: begin
          // lower bounds follow from the earlier tests failing
          if (battery_voltage < thr.chg_extreme) begin
            lv_next  = LV_EXTREME;
            led_next = ~led;
          end else if (battery_voltage < thr.chg_mid) begin
            lv_next  = LV_ONE;
            led_next = ~led;
          end else if (battery_voltage < thr.chg_high) begin
            lv_next  = LV_TWO;
            led_next = 1'b1;
          end else if (battery_voltage < thr.chg_full) begin
            lv_next  = LV_THREE;
            led_next = 1'b1;
          end else if (battery_voltage >= thr.chg_full) begin
            lv_next  = LV_FULL;
            led_next = 1'b1;
          end
        end
        LV_EXTREME: begin
          led_next = ~led;
          if (battery_voltage >= thr.chg_extreme) lv_next = LV_ONE;
        end
        LV_ONE: begin
          led_next = ~led;
          if (battery_voltage >= thr.chg_mid) lv_next = LV_TWO;
        end
        LV_TWO: begin
          led_next = ~led;
          if (battery_voltage >= thr.chg_high) lv_next = LV_THREE;
        end
        LV_THREE: begin
          led_next = ~led;
          if (battery_voltage >= thr.chg_full) lv_next = LV_FOUR;
        end
        LV_FOUR, LV_FULL: led_next = 1'b1;
        default: ;
      endcase
    end else begin
      case (level)
        LV_IDLE: begin
          if (battery_voltage < thr.dis_extreme) lv_next = LV_EXTREME;
          else if (battery_voltage < thr.dis_mid) lv_next = LV_ONE;
          else if (battery_voltage < thr.dis_high) lv_next = LV_TWO;
          else lv_next = LV_THREE;
        end
        LV_EXTREME: poff = (battery_voltage < Cutoff);
        LV_ONE:   if (battery_voltage < thr.dis_extreme) lv_next = LV_EXTREME;
        LV_TWO:   if (battery_voltage < thr.dis_low) lv_next = LV_ONE;
        LV_THREE: if (battery_voltage < thr.dis_mid) lv_next = LV_TWO;
        LV_FOUR:  if (battery_voltage < thr.dis_high) lv_next = LV_THREE;
        default:  lv_next = LV_FOUR;
      endcase
      led_next = (lv_next == LV_EXTREME) ? ~led : 1'b1;
    end
  end

  always_comb begin
    res.level = lv_next;
    res.led   = led_next;
    res.poff  = poff;
    res.chg   = chg;
    case (charger_state)
      CS_CHARGING: res.status = ST_CHARGING;
      CS_COMPLETE: res.status = ST_COMPLETE;
      default:     res.status = ST_NORMAL;
    endcase
  end

endmodule

// ===== src/battery_level_indicator_top.sv =====
// Battery level indicator: with hysteresis.
// Channels: input (in_valid/in_ready) carries ext_supply, charger_state and
// battery_voltage; output (out_valid/out_ready) carries display_level, led_on,
// shutdown_req, charging and battery_status, one result per input transfer.
// Configuration: cfg_we writes cfg_data to threshold register cfg_index
// (0..7) at the clock edge. Writes must happen only while no item is in
// flight; the block does not enforce this. An accepted item waits in
// the input register, its result in the result register: two stages, with
// the level update between them. Throughput: one item per cycle while the
// output is not stalled; the level and LED state close their loop within
// the single update stage, so back-to-back items see each other.
// Reset (rst, synchronous): level goes idle, LED off, thresholds return to
// their defaults, both stages empty.
// Stall: while out_ready is low the result holds; one more item may wait in
// the input register, then in_ready drops until the result is taken.
// Depends on bli_pkg, bli_cfg and bli_update.
module battery_level_indicator_top
  import bli_pkg::*;
#(
  parameter int unsigned CUTOFF_LEVEL = CUTOFF_LEVEL_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               ext_supply,
  input  logic [1:0]         charger_state,
  input  volt_t              battery_voltage,
  output logic               out_valid,
  input  logic               out_ready,
  output level_t             display_level,
  output logic               led_on,
  output logic               shutdown_req,
  output logic               charging,
  output logic [1:0]         battery_status,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  volt_t              cfg_data
);

  thresh_t    thr;
  result_t    res;

  logic       s1_valid;
  logic       s1_ext;
  logic [1:0] s1_cs;
  volt_t      s1_volt;

  level_t     level;
  logic       led;
  logic       out_take;
  logic       s1_adv;

  assign out_take = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_take;
  assign in_ready = !s1_valid || out_take;

  bli_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  bli_update #(
    .CUTOFF_LEVEL (CUTOFF_LEVEL)
  ) u_update (
    .level           (level),
    .led             (led),
    .ext_supply      (s1_ext),
    .charger_state   (s1_cs),
    .battery_voltage (s1_volt),
    .thr             (thr),
    .res             (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_ext  <= ext_supply;
      s1_cs   <= charger_state;
      s1_volt <= battery_voltage;
    end
  end

  // level state and result register advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= LV_IDLE;
      led       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_take) out_valid <= s1_valid;
      if (s1_adv) begin
        level <= res.level;
        led   <= res.led;
      end
    end
    if (s1_adv) begin
      display_level  <= res.level;
      led_on         <= res.led;
      shutdown_req   <= res.poff;
      charging       <= res.chg;
      battery_status <= res.status;
    end
  end

`ifndef SYNTHESIS
  a_poff_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && shutdown_req |-> display_level == LV_EXTREME)
    else $error("shutdown_req outside extreme level");

  a_led_discharge: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !(s1_ext && res.chg) && res.level != LV_EXTREME |=> led_on)
    else $error("LED not forced on while discharging");

  a_state_tracks_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> level == display_level && led == led_on)
    else $error("level state diverged from result");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without full pipeline");

  a_no_code_seven: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> display_level != 3'd7)
    else $error("unused level code reached");
`endif

endmodule
